FILE: sv/idwm_pkg.sv
`timescale 1ns / 1ps
package idwm_pkg;

	localparam logic [7:0] CTRL_COMMAND = 8'h00;
	localparam logic [7:0] CTRL_DATA    = 8'h40;

	localparam logic [7:0] DEV_ADDR_RESET    = 8'd120;
	localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

	localparam logic REG_DEV_ADDR    = 1'b0;
	localparam logic REG_ACK_TIMEOUT = 1'b1;

	typedef struct packed {
		logic       go;
		logic       op;
		logic [7:0] payload;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic scl;
		logic sda_out;
		logic sda_release;
		logic busy;
		logic done;
		logic nack;
	} pins_t;

	typedef struct packed {
		logic  valid;
		tick_t data;
	} q_head_t;

endpackage

FILE: sv/idwm_tick_queue.sv
`timescale 1ns / 1ps
module idwm_tick_queue import idwm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  tick_t   push_data,
	output logic    full,
	input  logic    pop,
	output q_head_t head
);

	tick_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full       = count_q[1];
	assign head.valid = (count_q != 2'd0);
	assign head.data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/idwm_bus_seq.sv
`timescale 1ns / 1ps
module idwm_bus_seq import idwm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    cfg_index,
	input  logic [7:0] cfg_data,
	input  q_head_t head,
	output logic    pop,
	output logic    res_valid,
	input  logic    res_ready,
	output pins_t   res
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_LOW,
		PH_BIT_SET,
		PH_BIT_HIGH,
		PH_BIT_LOW,
		PH_ACK_RELEASE,
		PH_ACK_HIGH,
		PH_ACK_WAIT,
		PH_STOP_SCL_LOW,
		PH_STOP_SDA_LOW,
		PH_STOP_SCL_HIGH,
		PH_STOP_SDA_HIGH
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [1:0] byte_q, byte_d;
	logic [2:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [7:0] held_payload_q, held_payload_d;
	logic       held_op_q, held_op_d;
	logic [7:0] wait_q, wait_d;
	logic       err_q, err_d;
	logic [7:0] dev_addr_q;
	logic [7:0] timeout_q;
	logic       res_valid_q;
	pins_t      res_q;
	pins_t      pins;
	logic       msb;
	logic [8:0] wait_next;
	tick_t      t;

	assign t         = head.data;
	assign pop       = head.valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign msb       = shift_q[7];
	assign wait_next = {1'b0, wait_q} + 9'd1;

	always_comb begin
		phase_d        = phase_q;
		byte_d         = byte_q;
		bit_d          = bit_q;
		shift_d        = shift_q;
		held_payload_d = held_payload_q;
		held_op_d      = held_op_q;
		wait_d         = wait_q;
		err_d          = err_q;
		pins           = '{scl: 1'b1, sda_out: 1'b1, sda_release: 1'b0,
		                   busy: 1'b1, done: 1'b0, nack: 1'b0};
		case (phase_q)
			PH_START_LOW: begin
				pins.scl = 1'b0; pins.sda_out = 1'b0;
				phase_d = PH_BIT_SET;
			end
			PH_BIT_SET: begin
				pins.scl = 1'b0; pins.sda_out = msb;
				phase_d = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: begin
				pins.sda_out = msb;
				phase_d = PH_BIT_LOW;
			end
			PH_BIT_LOW: begin
				pins.scl = 1'b0; pins.sda_out = msb;
				shift_d = {shift_q[6:0], 1'b0};
				if (bit_q == 3'd7) begin
					bit_d   = 3'd0;
					phase_d = PH_ACK_RELEASE;
				end else begin
					bit_d   = bit_q + 3'd1;
					phase_d = PH_BIT_SET;
				end
			end
			PH_ACK_RELEASE: begin
				pins.scl = 1'b0; pins.sda_release = 1'b1;
				wait_d  = 8'd0;
				phase_d = PH_ACK_HIGH;
			end
			PH_ACK_HIGH: begin
				pins.sda_release = 1'b1;
				phase_d = PH_ACK_WAIT;
			end
			PH_ACK_WAIT: begin
				pins.sda_release = 1'b1;
				if (!t.sda_in) begin
					pins.scl = 1'b0;
					if (byte_q >= 2'd2) begin
						phase_d = PH_STOP_SDA_LOW;
					end else begin
						byte_d  = byte_q + 2'd1;
						shift_d = (byte_q == 2'd0)
						          ? (held_op_q ? CTRL_DATA : CTRL_COMMAND)
						          : held_payload_q;
						bit_d   = 3'd0;
						phase_d = PH_BIT_SET;
					end
				end else if (wait_next > {1'b0, timeout_q}) begin
					err_d   = 1'b1;
					phase_d = PH_STOP_SCL_LOW;
				end else begin
					wait_d = wait_next[7:0];
				end
			end
			PH_STOP_SCL_LOW: begin
				pins.scl = 1'b0; pins.sda_release = 1'b1;
				phase_d = PH_STOP_SDA_LOW;
			end
			PH_STOP_SDA_LOW: begin
				pins.scl = 1'b0; pins.sda_out = 1'b0;
				phase_d = PH_STOP_SCL_HIGH;
			end
			PH_STOP_SCL_HIGH: begin
				pins.sda_out = 1'b0;
				phase_d = PH_STOP_SDA_HIGH;
			end
			PH_STOP_SDA_HIGH: begin
				pins.done = 1'b1;
				pins.nack = err_q;
				phase_d = PH_IDLE;
			end
			default: begin
				if (t.go) begin
					held_payload_d = t.payload;
					held_op_d      = t.op;
					shift_d        = dev_addr_q;
					byte_d         = 2'd0;
					bit_d          = 3'd0;
					wait_d         = 8'd0;
					err_d          = 1'b0;
					pins.sda_out   = 1'b0;
					phase_d        = PH_START_LOW;
				end else begin
					pins.busy = 1'b0;
					phase_d   = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			byte_q         <= 2'd0;
			bit_q          <= 3'd0;
			shift_q        <= 8'd0;
			held_payload_q <= 8'd0;
			held_op_q      <= 1'b0;
			wait_q         <= 8'd0;
			err_q          <= 1'b0;
			dev_addr_q     <= DEV_ADDR_RESET;
			timeout_q      <= ACK_TIMEOUT_RESET;
			res_valid_q    <= 1'b0;
			res_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEV_ADDR:    dev_addr_q <= cfg_data;
					REG_ACK_TIMEOUT: timeout_q  <= cfg_data;
					default:         dev_addr_q <= dev_addr_q;
				endcase
			end
			if (pop) begin
				phase_q        <= phase_d;
				byte_q         <= byte_d;
				bit_q          <= bit_d;
				shift_q        <= shift_d;
				held_payload_q <= held_payload_d;
				held_op_q      <= held_op_d;
				wait_q         <= wait_d;
				err_q          <= err_d;
				res_q          <= pins;
				res_valid_q    <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/i2c_display_write_master.sv
`timescale 1ns / 1ps
// i2c write master for a display controller, one bus tick per beat. each input
// beat yields exactly one output beat with the pin levels for that tick. the
// block sustains one beat per clock while neither side stalls: a two-entry
// tick queue feeds the bus sequencer, whose result sits in an output
// register, so each side may stall on its own. output valid is registered:
// a popped tick's pin levels land in the output register. configuration:
// index 0 device address, index 1 ack timeout; write only while idle.
module i2c_display_write_master import idwm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       go,
	input  logic       op,
	input  logic [7:0] payload,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl,
	output logic       sda_out,
	output logic       sda_release,
	output logic       busy_res,
	output logic       done_res,
	output logic       nack_error
);

	tick_t   in_tick;
	q_head_t head;
	logic    full;
	logic    pop;
	pins_t   res;

	assign in_tick  = '{go: go, op: op, payload: payload, sda_in: sda_in};
	assign in_ready = !full;

	idwm_tick_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_data (in_tick),
		.full      (full),
		.pop       (pop),
		.head      (head)
	);

	idwm_bus_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.pop       (pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign scl         = res.scl;
	assign sda_out     = res.sda_out;
	assign sda_release = res.sda_release;
	assign busy_res    = res.busy;
	assign done_res    = res.done;
	assign nack_error  = res.nack;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done without busy");

	a_nack_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nack_error |-> done_res)
		else $error("nack without done");

	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sda_release |-> sda_out && busy_res)
		else $error("sda released while driven low or idle");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("queue full without output stall");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import idwm_pkg::*;

	localparam int QUIET_LIMIT = 500;

	typedef enum logic [3:0] {
		S_IDLE, S_START_LOW, S_BIT_SET, S_BIT_HIGH, S_BIT_LOW, S_ACK_REL, S_ACK_HIGH,
		S_ACK_WAIT, S_STOP_SCL_LOW, S_STOP_SDA_LOW, S_STOP_SCL_HIGH, S_STOP_SDA_HIGH
	} bus_state_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       go = 1'b0;
	logic       op = 1'b0;
	logic [7:0] payload = '0;
	logic       sda_in = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       scl;
	logic       sda_out;
	logic       sda_release;
	logic       busy_res;
	logic       done_res;
	logic       nack_error;

	// bus sequencer state and register copies
	bus_state_t bus_ph = S_IDLE;
	logic [1:0] byte_idx = '0;
	logic [2:0] bit_idx = '0;
	logic [7:0] shreg = '0;
	logic [7:0] latched_payload = '0;
	logic       latched_op = 1'b0;
	logic [7:0] ack_wait = '0;
	logic       timed_out = 1'b0;
	logic [7:0] addr_reg = DEV_ADDR_RESET;
	logic [7:0] tmo_reg = ACK_TIMEOUT_RESET;

	tick_t tick_backlog[$];
	pins_t pins_due[$];
	tick_t head;
	pins_t due;

	int in_gap = 0;
	int out_stall = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int beats_checked = 0;
	int writes_started = 0;
	int aborted_writes = 0;

	i2c_display_write_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.go(go),
		.op(op),
		.payload(payload),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl(scl),
		.sda_out(sda_out),
		.sda_release(sda_release),
		.busy_res(busy_res),
		.done_res(done_res),
		.nack_error(nack_error)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic pins_t next_pins(tick_t t);
		pins_t p;
		int unsigned nxt;
		p.scl = 1'b1;
		p.sda_out = 1'b1;
		p.sda_release = 1'b0;
		p.busy = 1'b1;
		p.done = 1'b0;
		p.nack = 1'b0;
		case (bus_ph)
		S_START_LOW: begin
			p.scl = 1'b0;
			p.sda_out = 1'b0;
			bus_ph = S_BIT_SET;
		end
		S_BIT_SET: begin
			p.scl = 1'b0;
			p.sda_out = shreg[7];
			bus_ph = S_BIT_HIGH;
		end
		S_BIT_HIGH: begin
			p.sda_out = shreg[7];
			bus_ph = S_BIT_LOW;
		end
		S_BIT_LOW: begin
			p.scl = 1'b0;
			p.sda_out = shreg[7];
			shreg = shreg << 1;
			if (bit_idx == 3'd7) begin
				bit_idx = '0;
				bus_ph = S_ACK_REL;
			end else begin
				bit_idx = bit_idx + 3'd1;
				bus_ph = S_BIT_SET;
			end
		end
		S_ACK_REL: begin
			p.scl = 1'b0;
			p.sda_release = 1'b1;
			ack_wait = '0;
			bus_ph = S_ACK_HIGH;
		end
		S_ACK_HIGH: begin
			p.sda_release = 1'b1;
			bus_ph = S_ACK_WAIT;
		end
		S_ACK_WAIT: begin
			p.sda_release = 1'b1;
			if (!t.sda_in) begin
				p.scl = 1'b0;
				if (byte_idx >= 2'd2) begin
					bus_ph = S_STOP_SDA_LOW;
				end else begin
					byte_idx = byte_idx + 2'd1;
					shreg = (byte_idx == 2'd1) ? (latched_op ? CTRL_DATA : CTRL_COMMAND)
						: latched_payload;
					bit_idx = '0;
					bus_ph = S_BIT_SET;
				end
			end else begin
				nxt = ack_wait + 1;
				if (nxt > tmo_reg) begin
					timed_out = 1'b1;
					aborted_writes++;
					bus_ph = S_STOP_SCL_LOW;
				end else begin
					ack_wait = nxt[7:0];
				end
			end
		end
		S_STOP_SCL_LOW: begin
			p.scl = 1'b0;
			p.sda_release = 1'b1;
			bus_ph = S_STOP_SDA_LOW;
		end
		S_STOP_SDA_LOW: begin
			p.scl = 1'b0;
			p.sda_out = 1'b0;
			bus_ph = S_STOP_SCL_HIGH;
		end
		S_STOP_SCL_HIGH: begin
			p.sda_out = 1'b0;
			bus_ph = S_STOP_SDA_HIGH;
		end
		S_STOP_SDA_HIGH: begin
			p.done = 1'b1;
			p.nack = timed_out;
			bus_ph = S_IDLE;
		end
		default: begin
			if (t.go) begin
				latched_payload = t.payload;
				latched_op = t.op;
				shreg = addr_reg;
				byte_idx = '0;
				bit_idx = '0;
				ack_wait = '0;
				timed_out = 1'b0;
				p.sda_out = 1'b0;
				bus_ph = S_START_LOW;
				writes_started++;
			end else begin
				p.busy = 1'b0;
				bus_ph = S_IDLE;
			end
		end
		endcase
		return p;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// high samples before the ack; above the timeout means an abort
	function automatic int pick_ack();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, (tmo_reg < 4) ? tmo_reg : 4);
		if (r < 90)
			return (tmo_reg <= 16 || r == 80) ? tmo_reg : $urandom_range(5, 16);
		return (tmo_reg <= 16 || r == 90) ? tmo_reg + 1 : 0;
	endfunction

	function automatic void check_bit(string field, logic want_v, logic got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0b, got %0b", field, want_v, got_v);
			mismatches++;
		end
	endfunction

	task automatic add_tick(bit g, bit o, bit [7:0] p, bit s);
		tick_t t;
		t.go = g;
		t.op = o;
		t.payload = p;
		t.sda_in = s;
		tick_backlog.push_back(t);
	endtask

	task automatic busy_tick(bit hold, bit s);
		add_tick(hold | 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)), s);
	endtask

	task automatic filler(int n, bit hold);
		repeat (n) busy_tick(hold, 1'($urandom_range(0, 1)));
	endtask

	task automatic idle(int n);
		repeat (n) add_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endtask

	// one write transaction laid out tick by tick against the current timeout
	task automatic send_write(bit opv, bit [7:0] pl, int h0, int h1, int h2, bit hold);
		int plan[3];
		plan[0] = h0;
		plan[1] = h1;
		plan[2] = h2;
		add_tick(1'b1, opv, pl, 1'($urandom_range(0, 1)));
		filler(1, hold);
		for (int b = 0; b < 3; b++) begin
			filler(26, hold);
			if (plan[b] > tmo_reg) begin
				repeat (tmo_reg + 1) busy_tick(hold, 1'b1);
				filler(4, hold);
				return;
			end
			repeat (plan[b]) busy_tick(hold, 1'b1);
			busy_tick(hold, 1'b0);
		end
		filler(3, hold);
	endtask

	task automatic settle();
		forever begin
			@(negedge clk);
			if (tick_backlog.size() == 0 && !in_valid && pins_due.size() == 0) begin
				if (bus_ph == S_IDLE)
					break;
				add_tick(1'b0, 1'b0, 8'h00, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_DEV_ADDR)
			addr_reg = val;
		else
			tmo_reg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [7:0] a, logic [7:0] t);
		settle();
		write_reg(REG_DEV_ADDR, a);
		write_reg(REG_ACK_TIMEOUT, t);
		@(negedge clk);
	endtask

	// tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			go <= 1'b0;
			op <= 1'b0;
			payload <= '0;
			sda_in <= 1'b0;
			in_gap <= 0;
		end else begin
			if ($urandom_range(0, 99) == 0)
				in_calm <= !in_calm;
			if (in_valid && in_ready)
				pins_due.push_back(next_pins({go, op, payload, sda_in}));
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (tick_backlog.size() != 0) begin
					head = tick_backlog.pop_front();
					go <= head.go;
					op <= head.op;
					payload <= head.payload;
					sda_in <= head.sda_in;
					in_valid <= 1'b1;
					in_gap <= in_calm ? 0 : gap_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// pin monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
			quiet_cycles <= 0;
		end else begin
			if ($urandom_range(0, 99) == 0)
				out_calm <= !out_calm;
			if (out_stall != 0) begin
				out_ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				out_ready <= 1'b1;
				out_stall <= out_calm ? 0 : gap_len();
			end
			if (out_valid && out_ready) begin
				beats_checked++;
				if (pins_due.size() == 0) begin
					$error("pin beat arrived with nothing expected");
					mismatches++;
				end else begin
					due = pins_due.pop_front();
					check_bit("scl", due.scl, scl);
					check_bit("sda_out", due.sda_out, sda_out);
					check_bit("sda_release", due.sda_release, sda_release);
					check_bit("busy_res", due.busy, busy_res);
					check_bit("done_res", due.done, done_res);
					check_bit("nack_error", due.nack, nack_error);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default registers, go held through a whole write
		send_write(1'b0, 8'h00, 0, 0, 0, 1'b0);
		send_write(1'b1, 8'hFF, 1, 0, 2, 1'b1);
		idle(2);

		// zero timeout: first high sample aborts
		configure(8'h00, 8'd0);
		send_write(1'b1, 8'h81, 1, 0, 0, 1'b0);
		send_write(1'b0, 8'h3C, 0, 0, 0, 1'b0);

		// widest timeout: 255 high samples pass, the next one aborts
		configure(8'hA5, 8'd255);
		send_write(1'b0, 8'hC3, 256, 0, 0, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
			0: configure(8'($urandom_range(0, 255)), 8'd1);
			1: configure(8'hFF, 8'd2);
			2: configure(8'h00, 8'd255);
			3: configure(8'($urandom_range(0, 255)), 8'($urandom_range(3, 16)));
			4: configure(8'($urandom_range(0, 255)), 8'd3);
			default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
			endcase
			send_write(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				pick_ack(), pick_ack(), pick_ack(), 1'b0);
			idle(($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
			// unstructured ticks to shake out odd go and sda sequences
			repeat ($urandom_range(10, 30))
				add_tick($urandom_range(0, 9) < 3, 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end

		settle();
		repeat (8) @(posedge clk);
		$display("checked %0d pin beats over %0d write transactions", beats_checked,
			writes_started);
		$display("%0d transactions aborted on ack timeout, timeouts from 0 to 255",
			aborted_writes);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
